>>> sv/tlpt_pkg.sv
`timescale 1ns / 1ps

package tlpt_pkg;

    localparam int MEM_WORD_ADDR_BITS = 16;
    localparam int TABLE_IDX_BITS     = 10;
    localparam int PAGE_HI_BITS       = 20;
    localparam int DIR_SHIFT          = 22;
    localparam int PAGE_SHIFT         = 12;
    localparam logic [31:0] PAGE_BYTES = 32'd4096;

    localparam int S_DATA_BITS    = 104;
    localparam int M_DATA_BITS    = 72;
    localparam int CFG_INDEX_BITS = 1;

    typedef enum logic [1:0] {
        ACT_MAP   = 2'd0,
        ACT_UNMAP = 2'd1,
        ACT_KPAGE = 2'd2,
        ACT_TPAGE = 2'd3
    } tlpt_action_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_KERNEL_POOL = 1'b0,
        REG_TASK_POOL   = 1'b1
    } tlpt_cfg_reg_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PDE_RD,
        S_PDE_CHK,
        S_ZERO,
        S_PDE_WR,
        S_PTE_WR,
        S_PTE_RD,
        S_PTE_CHK,
        S_OUT
    } tlpt_state_t;

    typedef struct packed {
        logic kernel_pg;
        logic task_pg;
    } tlpt_take_t;

    function automatic logic [31:0] make_entry(input logic [PAGE_HI_BITS-1:0] hi,
                                               input logic [1:0] rights);
        make_entry = {hi, 9'd0, rights, 1'b1};
    endfunction

endpackage

>>> sv/tlpt_alloc.sv
`timescale 1ns / 1ps

module tlpt_alloc
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr,
    input  logic [tlpt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]                         cfg_data,
    input  tlpt_pkg::tlpt_take_t                take,
    output logic [31:0]                         kernel_page,
    output logic [31:0]                         task_page
);
    import tlpt_pkg::*;

    logic [31:0] kernel_next_reg;
    logic [31:0] task_next_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_next_reg <= '0;
            task_next_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (tlpt_cfg_reg_t'(cfg_index))
                REG_KERNEL_POOL: kernel_next_reg <= cfg_data;
                REG_TASK_POOL:   task_next_reg   <= cfg_data;
            endcase
        end
        else
        begin
            if (take.kernel_pg)
            begin
                kernel_next_reg <= kernel_next_reg + PAGE_BYTES;
            end
            if (take.task_pg)
            begin
                task_next_reg <= task_next_reg + PAGE_BYTES;
            end
        end
    end

    assign kernel_page = kernel_next_reg;
    assign task_page   = task_next_reg;

endmodule

>>> sv/two_level_page_table_mapper_unit.sv
`timescale 1ns / 1ps

// Page table editor over a private word memory, using the 32-bit two-level x86 layout.
// Requests arrive on the s_ channel: the action travels in s_tuser, the addresses
// and access bits in s_tdata. Every request gives exactly one result transfer on
// the m_ channel. The two pool registers are written through the cfg_ channel,
// which is always ready and should only be used while the engine is idle.
// After reset the engine clears all 65536 memory words, one per cycle, and
// accepts no request until that pass is over.
// Allocator actions go straight to the result. A map through a present directory
// entry reads it, then writes the table entry. An unmap reads both entries and writes
// the table entry back with the present bit clear, or stops after the directory read
// if that entry is absent. Each read has an address step and a registered data step.
// A new table's 1024 words are cleared one at a time on the single memory write port.
// One request is handled at a time. s_tready is high only while the sequencer waits
// for work. The result sits in an output register, so a new request can be taken
// while the receiver stalls. A finished result waits in the sequencer until that
// register is free.

module two_level_page_table_mapper_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tlpt_pkg::S_DATA_BITS-1:0]    s_tdata,  // directory_base, virtual_address,
                                                          // physical_address, access_bits
    input  logic [1:0]                          s_tuser,  // action
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tlpt_pkg::M_DATA_BITS-1:0]    m_tdata,  // result_value, directory_entry,
                                                          // table_allocated
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tlpt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]                         cfg_data
);
    import tlpt_pkg::*;

    localparam int MW = MEM_WORD_ADDR_BITS;

    tlpt_state_t state_reg;
    tlpt_state_t state_next;

    logic [MW-1:0]             cnt_reg;
    tlpt_action_t              act_reg;
    logic [PAGE_HI_BITS-1:0]   dir_hi_reg;
    logic [TABLE_IDX_BITS-1:0] dir_idx_reg;
    logic [TABLE_IDX_BITS-1:0] tab_idx_reg;
    logic [PAGE_HI_BITS-1:0]   phys_hi_reg;
    logic [1:0]                rights_reg;
    logic [PAGE_HI_BITS-1:0]   tab_hi_reg;
    logic [31:0]               pde_reg;
    logic [31:0]               res_reg;
    logic                      made_reg;
    logic [M_DATA_BITS-1:0]    out_data_reg;
    logic                      out_valid_reg;

    logic [31:0]   mem [1 << MW];
    logic [31:0]   rd_data_reg;
    logic [MW-1:0] mem_addr;
    logic          mem_we;
    logic [31:0]   mem_wdata;

    logic          s_accept;
    logic          out_free;
    logic          zero_done;
    logic          pde_present;
    tlpt_action_t  in_act;
    tlpt_take_t    take;
    logic [31:0]   kernel_page;
    logic [31:0]   task_page;
    logic [31:0]   pde_byte;
    logic [31:0]   pte_byte;
    logic [31:0]   zero_byte;
    logic [31:0]   new_pte;

    tlpt_alloc u_alloc
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .take        (take),
        .kernel_page (kernel_page),
        .task_page   (task_page)
    );

    assign in_act      = tlpt_action_t'(s_tuser);
    assign s_accept    = s_tvalid & s_tready;
    assign out_free    = !out_valid_reg || m_tready;
    assign zero_done   = (cnt_reg[TABLE_IDX_BITS-1:0] == {TABLE_IDX_BITS{1'b1}});
    assign pde_present = rd_data_reg[0];
    assign cfg_ready   = 1'b1;

    assign pde_byte  = {dir_hi_reg, dir_idx_reg, 2'b00};
    assign pte_byte  = {tab_hi_reg, tab_idx_reg, 2'b00};
    assign zero_byte = {tab_hi_reg, cnt_reg[TABLE_IDX_BITS-1:0], 2'b00};
    assign new_pte   = make_entry(phys_hi_reg, rights_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (cnt_reg == {MW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_accept)
                begin
                    if (in_act == ACT_MAP || in_act == ACT_UNMAP)
                    begin
                        state_next = S_PDE_RD;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_PDE_RD:
            begin
                state_next = S_PDE_CHK;
            end
            S_PDE_CHK:
            begin
                if (act_reg == ACT_MAP)
                begin
                    state_next = pde_present ? S_PTE_WR : S_ZERO;
                end
                else
                begin
                    state_next = pde_present ? S_PTE_RD : S_OUT;
                end
            end
            S_ZERO:
            begin
                if (zero_done)
                begin
                    state_next = S_PDE_WR;
                end
            end
            S_PDE_WR:
            begin
                state_next = S_PTE_WR;
            end
            S_PTE_WR:
            begin
                state_next = S_OUT;
            end
            S_PTE_RD:
            begin
                state_next = S_PTE_CHK;
            end
            S_PTE_CHK:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready       = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = pde_byte[MW+1:2];
        mem_wdata      = '0;
        take.kernel_pg = 1'b0;
        take.task_pg   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = cnt_reg;
            end
            S_IDLE:
            begin
                s_tready       = 1'b1;
                take.kernel_pg = s_tvalid && (in_act == ACT_KPAGE);
                take.task_pg   = s_tvalid && (in_act == ACT_TPAGE);
            end
            S_PDE_CHK:
            begin
                take.kernel_pg = (act_reg == ACT_MAP) && !pde_present;
            end
            S_ZERO:
            begin
                mem_we   = 1'b1;
                mem_addr = zero_byte[MW+1:2];
            end
            S_PDE_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = pde_reg;
            end
            S_PTE_WR:
            begin
                mem_we    = 1'b1;
                mem_addr  = pte_byte[MW+1:2];
                mem_wdata = new_pte;
            end
            S_PTE_RD:
            begin
                mem_addr = pte_byte[MW+1:2];
            end
            S_PTE_CHK:
            begin
                mem_we    = 1'b1;
                mem_addr  = pte_byte[MW+1:2];
                mem_wdata = {rd_data_reg[31:1], 1'b0};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR || state_reg == S_ZERO)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    act_reg     <= in_act;
                    dir_hi_reg  <= s_tdata[31:PAGE_SHIFT];
                    dir_idx_reg <= s_tdata[32+DIR_SHIFT +: TABLE_IDX_BITS];
                    tab_idx_reg <= s_tdata[32+PAGE_SHIFT +: TABLE_IDX_BITS];
                    phys_hi_reg <= s_tdata[64+PAGE_SHIFT +: PAGE_HI_BITS];
                    rights_reg  <= s_tdata[98:97];
                    pde_reg     <= '0;
                    made_reg    <= 1'b0;
                    res_reg     <= (in_act == ACT_KPAGE) ? kernel_page : task_page;
                end
            end
            S_PDE_CHK:
            begin
                if (pde_present)
                begin
                    pde_reg    <= rd_data_reg;
                    tab_hi_reg <= rd_data_reg[31:PAGE_SHIFT];
                end
                else if (act_reg == ACT_MAP)
                begin
                    pde_reg    <= make_entry(kernel_page[31:PAGE_SHIFT], rights_reg);
                    tab_hi_reg <= kernel_page[31:PAGE_SHIFT];
                    made_reg   <= 1'b1;
                end
                else
                begin
                    pde_reg <= rd_data_reg;
                    res_reg <= '0;
                end
            end
            S_PTE_WR:
            begin
                res_reg <= new_pte;
            end
            S_PTE_CHK:
            begin
                res_reg <= {rd_data_reg[31:1], 1'b0};
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_data_reg <= {7'd0, made_reg, pde_reg, res_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_zero_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ZERO && zero_done) |=> (state_reg == S_PDE_WR))
        else $error("table clear did not end after the last table word");

    a_made_present: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[64]) |-> m_tdata[32])
        else $error("new table reported without a present directory entry");

    a_unmap_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PTE_CHK) |-> (mem_we && !mem_wdata[0]))
        else $error("unmap wrote a table entry with the present bit set");

    a_take_place: assert property (@(posedge clk) disable iff (!rst_n)
        (take.kernel_pg || take.task_pg) |-> (state_reg == S_IDLE || state_reg == S_PDE_CHK))
        else $error("page taken from a pool outside a request");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("request accepted during the memory clearing pass");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import tlpt_pkg::*;

    localparam logic [31:0] PAGE_MASK = 32'hFFFFF000;
    localparam int TABLE_WORDS   = 1024;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int HOLD_CYCLES   = 2500;
    localparam int TAIL_CYCLES   = 20;

    typedef struct packed {
        tlpt_action_t action;
        logic [31:0]  pd_base;
        logic [31:0]  vaddr;
        logic [31:0]  paddr;
        logic [2:0]   access;
    } pt_request_t;

    typedef struct packed {
        logic [31:0] entry;
        logic [31:0] pde;
        logic        built;
    } pt_result_t;

    class page_table_shadow;
        bit [31:0]   words [1 << MEM_WORD_ADDR_BITS];
        logic [31:0] kernel_next;
        logic [31:0] task_next;
        pt_result_t  pending_results[$];
        int          mismatches;
        int          results_seen;
        int          n_map;
        int          n_unmap;
        int          n_take;
        int          tables_built;
        int          pool_writes;

        function new();
            kernel_next  = '0;
            task_next    = '0;
            mismatches   = 0;
            results_seen = 0;
            n_map        = 0;
            n_unmap      = 0;
            n_take       = 0;
            tables_built = 0;
            pool_writes  = 0;
        endfunction

        function logic [MEM_WORD_ADDR_BITS-1:0] slot(logic [31:0] byte_addr);
            return byte_addr[MEM_WORD_ADDR_BITS+1:2];
        endfunction

        function void set_pool(tlpt_cfg_reg_t idx, logic [31:0] value);
            if (idx == REG_KERNEL_POOL)
                kernel_next = value;
            else
                task_next = value;
            pool_writes++;
        endfunction

        function pt_result_t walk(pt_request_t r);
            logic [31:0] pde_addr;
            logic [31:0] tbl_base;
            logic [31:0] pte_addr;
            logic [31:0] rights;
            int          i;
            pt_result_t  o;
            o = '0;
            rights = {29'd0, r.access[2:1], 1'b0};
            pde_addr = (r.pd_base & PAGE_MASK) + {20'd0, r.vaddr[31:22], 2'b00};
            case (r.action)
                ACT_MAP:
                begin
                    o.pde = words[slot(pde_addr)];
                    if (!o.pde[0])
                    begin
                        tbl_base = kernel_next & PAGE_MASK;
                        kernel_next = kernel_next + PAGE_BYTES;
                        for (i = 0; i < TABLE_WORDS; i++)
                            words[slot(tbl_base + (i << 2))] = '0;
                        o.pde = tbl_base | rights | 32'd1;
                        words[slot(pde_addr)] = o.pde;
                        o.built = 1'b1;
                        tables_built++;
                    end
                    o.entry = (r.paddr & PAGE_MASK) | rights | 32'd1;
                    pte_addr = (o.pde & PAGE_MASK) + {20'd0, r.vaddr[21:12], 2'b00};
                    words[slot(pte_addr)] = o.entry;
                    n_map++;
                end
                ACT_UNMAP:
                begin
                    o.pde = words[slot(pde_addr)];
                    if (o.pde[0])
                    begin
                        pte_addr = (o.pde & PAGE_MASK) + {20'd0, r.vaddr[21:12], 2'b00};
                        o.entry = words[slot(pte_addr)] & ~32'd1;
                        words[slot(pte_addr)] = o.entry;
                    end
                    n_unmap++;
                end
                ACT_KPAGE:
                begin
                    o.entry = kernel_next;
                    kernel_next = kernel_next + PAGE_BYTES;
                    n_take++;
                end
                default:
                begin
                    o.entry = task_next;
                    task_next = task_next + PAGE_BYTES;
                    n_take++;
                end
            endcase
            return o;
        endfunction

        function void accept_request(pt_request_t r);
            pending_results.push_back(walk(r));
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task check_result(logic [M_DATA_BITS-1:0] d);
            pt_result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                          results_seen));
            end
            else
            begin
                want = pending_results.pop_front();
                if (d[31:0] !== want.entry)
                    report_mismatch($sformatf("result %0d value %h, predicted %h",
                                              results_seen, d[31:0], want.entry));
                if (d[63:32] !== want.pde)
                    report_mismatch($sformatf("result %0d directory entry %h, predicted %h",
                                              results_seen, d[63:32], want.pde));
                if (d[64] !== want.built)
                    report_mismatch($sformatf("result %0d table flag %b, predicted %b",
                                              results_seen, d[64], want.built));
            end
        endtask
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [S_DATA_BITS-1:0]    s_tdata = '0;
    logic [1:0]                s_tuser = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [M_DATA_BITS-1:0]    m_tdata;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [31:0]               cfg_data = '0;

    page_table_shadow shadow = new();
    pt_request_t      recent_map = '0;
    int               tx_idle_pct = 0;
    int               rx_stall_pct = 0;
    int               rx_hold_req = 0;
    int               rx_hold_seen = 0;
    int               rx_hold_left = 0;

    two_level_page_table_mapper_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // The receiver keeps its own count of a long hold so that the block backs up.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            shadow.check_result(m_tdata);
        if (rx_hold_req != rx_hold_seen)
        begin
            rx_hold_seen = rx_hold_req;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic offer(pt_request_t r);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.action;
        s_tdata  <= {5'd0, r.access, r.paddr, r.vaddr, r.pd_base};
        do @(posedge clk); while (!s_tready);
        shadow.accept_request(r);
    endtask

    task automatic send_fields(tlpt_action_t a, logic [31:0] d, logic [31:0] v,
                               logic [31:0] p, logic [2:0] acc);
        pt_request_t r;
        r = '{a, d, v, p, acc};
        offer(r);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (shadow.pending_results.size() != 0 || !s_tready);
    endtask

    task automatic configure_pools(logic [31:0] kernel_start, logic [31:0] task_start);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= REG_KERNEL_POOL;
        cfg_data  <= kernel_start;
        do @(posedge clk); while (!cfg_ready);
        shadow.set_pool(REG_KERNEL_POOL, kernel_start);
        cfg_index <= REG_TASK_POOL;
        cfg_data  <= task_start;
        do @(posedge clk); while (!cfg_ready);
        shadow.set_pool(REG_TASK_POOL, task_start);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_pool();
        case ($urandom_range(3))
            0:       return 32'd0;
            1:       return PAGE_MASK;
            2:       return $urandom() & PAGE_MASK;
            default: return $urandom_range(32'hFFFFF000, 0);
        endcase
    endfunction

    // Most requests land on a handful of directories and directory slots, so that
    // existing tables are reused and unmaps find real entries.
    function automatic pt_request_t random_request();
        pt_request_t r;
        logic [31:0] bits;
        logic [9:0]  hi;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 50)
            r.action = ACT_MAP;
        else if (pick < 75)
            r.action = ACT_UNMAP;
        else if (pick < 87)
            r.action = ACT_KPAGE;
        else
            r.action = ACT_TPAGE;
        bits = $urandom();
        if ($urandom_range(99) < 85)
            r.pd_base = {bits[31:18], 4'd0, 2'($urandom_range(3)), bits[11:0]};
        else
            r.pd_base = bits;
        case ($urandom_range(3))
            0:       hi = 10'd0;
            1:       hi = 10'd1;
            2:       hi = 10'd512;
            default: hi = 10'd1023;
        endcase
        bits = $urandom();
        r.vaddr  = ($urandom_range(99) < 80) ? {hi, bits[21:0]} : bits;
        r.paddr  = $urandom();
        r.access = 3'($urandom_range(7));
        if (r.action == ACT_UNMAP && $urandom_range(99) < 40)
        begin
            r.pd_base = recent_map.pd_base;
            r.vaddr   = recent_map.vaddr;
        end
        if (r.action == ACT_MAP)
            recent_map = r;
        return r;
    endfunction

    initial
    begin
        int phase;
        int n;
        int mode;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        configure_pools(32'h0002_0000, PAGE_MASK);
        send_fields(ACT_UNMAP, 32'h0, 32'h0040_1000, 32'h0, 3'd7);
        send_fields(ACT_MAP,   32'h0, 32'h0040_1000, 32'hFFFF_FFFF, 3'd7);
        send_fields(ACT_MAP,   32'h0, 32'h0040_2000, 32'h0, 3'd0);
        send_fields(ACT_UNMAP, 32'h0, 32'h0040_1000, 32'h0, 3'd0);
        send_fields(ACT_UNMAP, 32'h0, 32'h0040_1000, 32'h0, 3'd0);
        send_fields(ACT_MAP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5FFF, 3'd2);
        send_fields(ACT_MAP,   32'hFFFF_FFFF, 32'hFFC0_0000, 32'hABCD_E000, 3'd4);
        send_fields(ACT_KPAGE, 32'h0, 32'h0, 32'h0, 3'd0);
        send_fields(ACT_TPAGE, 32'h0, 32'h0, 32'h0, 3'd0);
        send_fields(ACT_TPAGE, 32'h0, 32'h0, 32'h0, 3'd0);
        // New table placed on top of the directory it is entered in.
        send_fields(ACT_MAP, shadow.kernel_next, {10'd5, 10'd5, 12'hABC}, 32'h5555_5000, 3'd6);
        send_fields(ACT_MAP, 32'h0000_1000, 32'h0, 32'h0000_0FFF, 3'd1);

        configure_pools(32'h0001_2345, 32'h8765_4321);
        send_fields(ACT_KPAGE, 32'h0, 32'h0, 32'h0, 3'd0);
        send_fields(ACT_MAP,   32'h0000_3000, 32'h8000_0000, 32'h0F0F_0000, 3'd6);
        send_fields(ACT_TPAGE, 32'h0, 32'h0, 32'h0, 3'd0);
        send_fields(ACT_KPAGE, 32'h0, 32'h0, 32'h0, 3'd0);

        configure_pools(PAGE_MASK, 32'h0);
        send_fields(ACT_MAP,   32'h0000_2000, 32'h7FC0_0000, 32'h8000_0000, 3'd2);
        send_fields(ACT_MAP,   32'h0000_2000, 32'h00C0_0000, 32'h7FFF_F000, 3'd4);
        send_fields(ACT_TPAGE, 32'h0, 32'h0, 32'h0, 3'd0);
        send_fields(ACT_UNMAP, 32'hFFFF_FFFF, 32'hFFFF_F000, 32'h0, 3'd0);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            configure_pools(pick_pool(), pick_pool());
            mode = phase % 4;
            tx_idle_pct  = (mode == 1) ? 81 : (mode == 3) ? 18 : 0;
            rx_stall_pct = (mode == 2) ? 81 : (mode == 3) ? 18 : 0;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 4 && n == 10)
                    rx_hold_req++;
                if (phase == 4 && n == 35)
                    drain_results();
                offer(random_request());
            end
        end
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d map (%0d built a table), %0d unmap, %0d page takes.",
                 shadow.n_map + shadow.n_unmap + shadow.n_take, shadow.n_map,
                 shadow.tables_built, shadow.n_unmap, shadow.n_take);
        $display("Pool registers written %0d times under four idling patterns and one long hold.",
                 shadow.pool_writes);
        if (shadow.mismatches == 0 && shadow.pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
